@@ hdl/ezrm_pkg.sv @@
// ezrm_pkg: shared constants, request/result types, arctangent table and rounding helpers
// for the zyx euler rotation matrix unit; no dependencies
package ezrm_pkg;

    localparam int AngleW = 16;
    localparam int OutW = 16;
    localparam int CordicW = 34;
    localparam int CordicStagesDef = 16;
    localparam int ZW = 36;

    localparam logic signed [AngleW-1:0] HalfPiQ13 = 16'sd12868;
    localparam logic signed [AngleW-1:0] PiQ13 = 16'sd25736;
    localparam logic signed [CordicW-1:0] GainQ30 = 34'sd652032874;
    localparam logic signed [OutW-1:0] OneQ14 = 16'sd16384;

    typedef logic signed [OutW-1:0] t_q14;
    typedef logic signed [CordicW-1:0] t_cord;
    typedef logic signed [ZW-1:0] t_zang;

    // request payload: three angles in q3.13
    typedef struct packed {
        logic signed [AngleW-1:0] roll_angle;
        logic signed [AngleW-1:0] pitch_angle;
        logic signed [AngleW-1:0] yaw_angle;
    } t_angles;

    // result payload: nine entries in q1.14, row by row
    typedef struct packed {
        t_q14 r00; t_q14 r01; t_q14 r02;
        t_q14 r10; t_q14 r11; t_q14 r12;
        t_q14 r20; t_q14 r21; t_q14 r22;
    } t_matrix;

    // payload of one cordic lane
    typedef struct packed {
        t_cord x;
        t_cord y;
        t_zang z;
    } t_cell_data;

    typedef struct packed {
        t_cell_data roll;
        t_cell_data pitch;
        t_cell_data yaw;
        logic [2:0] negc;
    } t_lane_set;

    // arctangent table, q.30 truncated
    function automatic t_zang atan_q30(input int idx);
        logic [31:0] v;
        begin
            case (idx)
                0: v = 32'h3243F6A8; 1: v = 32'h1DAC6705; 2: v = 32'h0FADBAFC;
                3: v = 32'h07F56EA6; 4: v = 32'h03FEAB76; 5: v = 32'h01FFD55B;
                6: v = 32'h00FFFAAA; 7: v = 32'h007FFF55; 8: v = 32'h003FFFEA;
                9: v = 32'h001FFFFD; 10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
                12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
                15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
                18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
                21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
                24: v = 32'h0000003F; 25: v = 32'h0000001F; 26: v = 32'h0000000F;
                27: v = 32'h00000008; 28: v = 32'h00000004; 29: v = 32'h00000002;
                30: v = 32'h00000001;
                default: v = 32'h00000000;
            endcase
            atan_q30 = t_zang'({4'b0000, v});
        end
    endfunction

    // saturate to +/-1.0 in q1.14
    function automatic t_q14 sat_q14(input logic signed [63:0] v);
        begin
            if (v > 64'sd16384) sat_q14 = OneQ14;
            else if (v < -64'sd16384) sat_q14 = -OneQ14;
            else sat_q14 = t_q14'(v[OutW-1:0]);
        end
    endfunction

    // q.30 cordic value to q1.14 with rounding
    function automatic t_q14 cord_to_q14(input t_cord v);
        logic signed [CordicW:0] t;
        begin
            t = {v[CordicW-1], v} + (CordicW+1)'(32768);
            cord_to_q14 = sat_q14(64'(t >>> 16));
        end
    endfunction

endpackage

@@ hdl/ezrm_stream_if.sv @@
// ezrm_stream_if: valid/ready channel carrying a generic payload
// depends on nothing
interface ezrm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/ezrm_cordic_cell.sv @@
// ezrm_cordic_cell: one rotation-mode cordic iteration for three angles
// depends on ezrm_pkg
module ezrm_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  ezrm_pkg::t_lane_set i_d,
    output ezrm_pkg::t_lane_set o_d
);
    ezrm_pkg::t_lane_set n_d;
    ezrm_pkg::t_lane_set r_d;

    function automatic ezrm_pkg::t_cell_data rot(input ezrm_pkg::t_cell_data c);
        ezrm_pkg::t_cell_data r;
        ezrm_pkg::t_cord dx;
        ezrm_pkg::t_cord dy;
        begin
            dx = c.y >>> STAGE;
            dy = c.x >>> STAGE;
            if (!c.z[ezrm_pkg::ZW-1]) begin
                r.x = c.x - dx;
                r.y = c.y + dy;
                r.z = c.z - ezrm_pkg::atan_q30(STAGE);
            end else begin
                r.x = c.x + dx;
                r.y = c.y - dy;
                r.z = c.z + ezrm_pkg::atan_q30(STAGE);
            end
            rot = r;
        end
    endfunction

    // micro-rotation of each lane
    always_comb begin
        n_d.roll = rot(i_d.roll);
        n_d.pitch = rot(i_d.pitch);
        n_d.yaw = rot(i_d.yaw);
        n_d.negc = i_d.negc;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_d <= n_d;
    end

    assign o_d = r_d;
endmodule

@@ hdl/ezrm_matrix.sv @@
// ezrm_matrix: sine/cosine rounding and pipelined matrix product
// depends on ezrm_pkg
module ezrm_matrix (
    input  logic                i_clk,
    input  logic                i_en,
    input  ezrm_pkg::t_lane_set i_d,
    output ezrm_pkg::t_q14      o_r [9]
);
    typedef logic signed [29:0] t_p2;
    typedef logic signed [47:0] t_p3;

    ezrm_pkg::t_q14 r_sr, r_cr, r_sp, r_cp, r_sy, r_cy;
    ezrm_pkg::t_q14 n_sr, n_cr, n_sp, n_cp, n_sy, n_cy;
    t_p2 r_sysr, r_sycr, r_cysr, r_cycr, r_sysp, r_cysp, r_cycp, r_sycp;
    t_p2 r_cpsr, r_cpcr, r_sp2;
    ezrm_pkg::t_q14 r_sr2, r_cr2;
    t_p3 r_e [9];
    t_p3 n_e [9];
    ezrm_pkg::t_q14 r_o [9];

    function automatic ezrm_pkg::t_q14 rnd42(input t_p3 v);
        logic signed [48:0] t;
        begin
            t = {v[47], v} + 49'sd134217728;
            rnd42 = ezrm_pkg::sat_q14(64'(t >>> 28));
        end
    endfunction

    // round cordic outputs, restore cosine sign
    always_comb begin
        n_sr = ezrm_pkg::cord_to_q14(i_d.roll.y);
        n_sp = ezrm_pkg::cord_to_q14(i_d.pitch.y);
        n_sy = ezrm_pkg::cord_to_q14(i_d.yaw.y);
        n_cr = ezrm_pkg::cord_to_q14(i_d.negc[0] ? -i_d.roll.x : i_d.roll.x);
        n_cp = ezrm_pkg::cord_to_q14(i_d.negc[1] ? -i_d.pitch.x : i_d.pitch.x);
        n_cy = ezrm_pkg::cord_to_q14(i_d.negc[2] ? -i_d.yaw.x : i_d.yaw.x);
    end

    // entry sums: registered second-order products plus third-order terms
    always_comb begin
        n_e[0] = t_p3'(r_cycp) <<< 14;
        n_e[1] = -(t_p3'(r_sycr) <<< 14) + r_cysp * r_sr2;
        n_e[2] = (t_p3'(r_sysr) <<< 14) + r_cysp * r_cr2;
        n_e[3] = t_p3'(r_sycp) <<< 14;
        n_e[4] = (t_p3'(r_cycr) <<< 14) + r_sysp * r_sr2;
        n_e[5] = -(t_p3'(r_cysr) <<< 14) + r_sysp * r_cr2;
        n_e[6] = -(t_p3'(r_sp2) <<< 28);
        n_e[7] = t_p3'(r_cpsr) <<< 14;
        n_e[8] = t_p3'(r_cpcr) <<< 14;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr <= n_sr; r_cr <= n_cr; r_sp <= n_sp;
            r_cp <= n_cp; r_sy <= n_sy; r_cy <= n_cy;
            r_sysr <= r_sy * r_sr; r_sycr <= r_sy * r_cr;
            r_cysr <= r_cy * r_sr; r_cycr <= r_cy * r_cr;
            r_sysp <= r_sy * r_sp; r_cysp <= r_cy * r_sp;
            r_cycp <= r_cy * r_cp; r_sycp <= r_sy * r_cp;
            r_cpsr <= r_cp * r_sr; r_cpcr <= r_cp * r_cr;
            r_sp2 <= t_p2'(r_sp);
            r_sr2 <= r_sr; r_cr2 <= r_cr;
            r_e <= n_e;
            for (int k = 0; k < 9; k++) r_o[k] <= rnd42(r_e[k]);
        end
    end

    assign o_r = r_o;
endmodule

@@ hdl/euler_zyx_rotation_matrix_unit.sv @@
// euler_zyx_rotation_matrix_unit: top level, angle fold, cordic cell chain,
// matrix stages; depends on ezrm_pkg, ezrm_stream_if, ezrm_cordic_cell, ezrm_matrix
// a request passes the fold register, the cordic cell chain and the matrix registers before its result is valid
// throughput: one request per cycle; the chain advances whenever the output
// register is empty or being taken
// reset: synchronous active low, clears the stage valid bits only
module euler_zyx_rotation_matrix_unit #(
    parameter int CORDIC_STAGES = ezrm_pkg::CordicStagesDef
) (
    input logic i_clk,
    input logic i_rst_n,
    ezrm_stream_if.sink   i_req,
    ezrm_stream_if.source o_res
);
    localparam int Lat = CORDIC_STAGES + 5;

    ezrm_pkg::t_lane_set s_lane [CORDIC_STAGES+1];
    ezrm_pkg::t_lane_set r_in;
    ezrm_pkg::t_lane_set n_in;
    ezrm_pkg::t_q14 s_r [9];
    logic [Lat-1:0] r_vld;
    logic s_en;

    assign s_en = !r_vld[Lat-1] || o_res.ready;
    assign i_req.ready = s_en;

    function automatic ezrm_pkg::t_cell_data fold(input logic [15:0] raw,
                                                  output logic negc);
        ezrm_pkg::t_cell_data c;
        logic signed [16:0] a;
        begin
            a = {raw[15], raw};
            negc = 1'b0;
            if (a > 17'(ezrm_pkg::HalfPiQ13)) begin
                a = 17'(ezrm_pkg::PiQ13) - a; negc = 1'b1;
            end else if (a < -17'(ezrm_pkg::HalfPiQ13)) begin
                a = -17'(ezrm_pkg::PiQ13) - a; negc = 1'b1;
            end
            c.x = ezrm_pkg::GainQ30;
            c.y = '0;
            c.z = ezrm_pkg::t_zang'(a) <<< 17;
            fold = c;
        end
    endfunction

    // fold angles into +/-pi/2
    always_comb begin
        n_in.roll = fold(i_req.data.roll_angle, n_in.negc[0]);
        n_in.pitch = fold(i_req.data.pitch_angle, n_in.negc[1]);
        n_in.yaw = fold(i_req.data.yaw_angle, n_in.negc[2]);
    end

    always_ff @(posedge i_clk) begin
        if (s_en) r_in <= n_in;
    end

    // valid bits track the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (s_en) r_vld <= {r_vld[Lat-2:0], i_req.valid};
    end

    assign s_lane[0] = r_in;

    // cordic cell chain
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        ezrm_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk(i_clk), .i_en(s_en), .i_d(s_lane[g]), .o_d(s_lane[g+1])
        );
    end

    ezrm_matrix u_mat (
        .i_clk(i_clk), .i_en(s_en), .i_d(s_lane[CORDIC_STAGES]), .o_r(s_r)
    );

    assign o_res.valid = r_vld[Lat-1];
    assign o_res.data.r00 = s_r[0];
    assign o_res.data.r01 = s_r[1];
    assign o_res.data.r02 = s_r[2];
    assign o_res.data.r10 = s_r[3];
    assign o_res.data.r11 = s_r[4];
    assign o_res.data.r12 = s_r[5];
    assign o_res.data.r20 = s_r[6];
    assign o_res.data.r21 = s_r[7];
    assign o_res.data.r22 = s_r[8];
endmodule

@@ hdl/ezrm_checker.sv @@
// ezrm_checker: port-level assertions for the rotation matrix unit
// bound to euler_zyx_rotation_matrix_unit
module ezrm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_vld,
    input logic i_rdy,
    input logic o_vld,
    input logic o_rdy,
    input logic signed [15:0] o_r22,
    input logic signed [15:0] o_r20
);
    // valid and entry r22 held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld && !o_rdy |=> o_vld && $stable(o_r22)) else $error("result dropped");
    // entries r22 and r20 within +/-1.0
    a_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> o_r22 <= 16'sd16384 && o_r22 >= -16'sd16384
                  && o_r20 <= 16'sd16384 && o_r20 >= -16'sd16384)
        else $error("entry out of range");
    // stall on output blocks requests
    a_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld && !o_rdy |-> !i_rdy) else $error("request taken under stall");
    // nothing out right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_vld) else $error("valid after reset");
endmodule

bind euler_zyx_rotation_matrix_unit ezrm_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_vld(i_req.valid), .i_rdy(i_req.ready),
    .o_vld(o_res.valid), .o_rdy(o_res.ready),
    .o_r22(o_res.data.r22), .o_r20(o_res.data.r20)
);

@@ tb/euler_zyx_rotation_matrix_unit_tb.sv @@
`timescale 1ns / 1ps
// euler_zyx_rotation_matrix_unit_tb: drives roll/pitch/yaw requests and checks the
// nine rotation matrix entries; depends on ezrm_pkg, ezrm_stream_if and the unit
module euler_zyx_rotation_matrix_unit_tb;

    // expected matrices and the fixed-point math that produces them
    class matrix_scoreboard;
        ezrm_pkg::t_matrix pending_q[$];
        int errors;
        int checked;
        longint atan_tab[32] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
            64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
            64'h00000001, 64'h00000000};

        function longint clamp_one(longint v);
            if (v > 16384) return 16384;
            if (v < -16384) return -16384;
            return v;
        endfunction

        // fold into +/-pi/2, rotate, round both to q1.14
        function void angle_sin_cos(logic signed [ezrm_pkg::AngleW-1:0] raw,
                                    output longint s, output longint c);
            longint a, x, y, z, dx, dy;
            bit flip;
            a = raw;
            flip = 0;
            x = 652032874;
            y = 0;
            if (a > 12868) begin
                a = 25736 - a;
                flip = 1;
            end else if (a < -12868) begin
                a = -25736 - a;
                flip = 1;
            end
            z = a * 131072;
            for (int i = 0; i < ezrm_pkg::CordicStagesDef && i < 32; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_tab[i];
                end else begin
                    x += dx; y -= dy; z += atan_tab[i];
                end
            end
            if (flip) x = -x;
            c = clamp_one((x + 32768) >>> 16);
            s = clamp_one((y + 32768) >>> 16);
        endfunction

        function ezrm_pkg::t_q14 to_q14(longint v);
            return ezrm_pkg::t_q14'(clamp_one((v + (64'sd1 <<< 27)) >>> 28));
        endfunction

        function void note_request(ezrm_pkg::t_angles a);
            longint sr, cr, sp, cp, sy, cy, k;
            ezrm_pkg::t_matrix m;
            k = 16384;
            angle_sin_cos(a.roll_angle, sr, cr);
            angle_sin_cos(a.pitch_angle, sp, cp);
            angle_sin_cos(a.yaw_angle, sy, cy);
            m.r00 = to_q14(cy * cp * k);
            m.r01 = to_q14(-sy * cr * k + cy * sp * sr);
            m.r02 = to_q14(sy * sr * k + cy * sp * cr);
            m.r10 = to_q14(sy * cp * k);
            m.r11 = to_q14(cy * cr * k + sy * sp * sr);
            m.r12 = to_q14(-cy * sr * k + sy * sp * cr);
            m.r20 = to_q14(-sp * k * k);
            m.r21 = to_q14(cp * sr * k);
            m.r22 = to_q14(cp * cr * k);
            pending_q.push_back(m);
        endfunction

        function void cmp(string name, ezrm_pkg::t_q14 exp_v, ezrm_pkg::t_q14 act_v);
            if (exp_v !== act_v) begin
                $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(ezrm_pkg::t_matrix act);
            ezrm_pkg::t_matrix e;
            if (pending_q.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            e = pending_q.pop_front();
            checked++;
            cmp("r00", e.r00, act.r00); cmp("r01", e.r01, act.r01);
            cmp("r02", e.r02, act.r02); cmp("r10", e.r10, act.r10);
            cmp("r11", e.r11, act.r11); cmp("r12", e.r12, act.r12);
            cmp("r20", e.r20, act.r20); cmp("r21", e.r21, act.r21);
            cmp("r22", e.r22, act.r22);
        endfunction
    endclass

    localparam int StallLimit = 5000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int sent = 0;
    matrix_scoreboard sb = new();

    ezrm_stream_if #(.T(ezrm_pkg::t_angles)) req_if ();
    ezrm_stream_if #(.T(ezrm_pkg::t_matrix)) res_if ();

    euler_zyx_rotation_matrix_unit uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_if.sink),
        .o_res(res_if.source)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        req_if.valid = 0;
        req_if.data = '0;
        res_if.ready = 0;
    end

    // receiver ready, with random idling and a long hold-off on demand
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result check and stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) sb.check_result(res_if.data);
            if ((res_if.valid && res_if.ready) || (req_if.valid && req_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= StallLimit) begin
                $display("watchdog: no progress, %0d results outstanding",
                         sb.pending_q.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // one request, held until accepted
    task automatic send_angles(logic signed [15:0] r, logic signed [15:0] p,
                               logic signed [15:0] y);
        ezrm_pkg::t_angles a;
        a.roll_angle = r;
        a.pitch_angle = p;
        a.yaw_angle = y;
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= a;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(a);
        sent++;
    endtask

    function automatic logic signed [15:0] pick_angle();
        if ($urandom_range(9) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(51472)) - 25736);
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) send_angles(pick_angle(), pick_angle(), pick_angle());
    endtask

    // sender stops until every outstanding result is back
    task automatic drain();
        req_if.valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (ezrm_pkg::CordicStagesDef + 10) @(posedge i_clk);
    endtask

    initial begin
        logic signed [15:0] corner[12] = '{0, 1, -1, 12868, -12868, 12869, -12869,
                                           25736, -25736, 6434, 32767, -32768};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners: folds at +/-pi/2, +/-pi, and patterns past pi
        for (int i = 0; i < 12; i++) send_angles(corner[i], corner[(i + 4) % 12],
                                                 corner[(i + 8) % 12]);
        send_angles(12868, 12868, 12868);
        send_angles(-25736, 25736, -12869);
        send_angles(16'h5555, 16'hAAAA, 16'h7FFF);
        drain();

        send_idle_pct = 10; recv_idle_pct = 69;
        random_phase(170);
        drain();

        send_idle_pct = 69; recv_idle_pct = 10;
        random_phase(160);
        drain();

        // no idling, plus a long receiver hold-off so the pipeline backs up
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(40);
        hold_left = 200;
        random_phase(130);
        drain();

        $display("sent %0d angle triples, checked %0d matrices across three idle mixes",
                 sent, sb.checked);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

@@ sim.f @@
hdl/ezrm_pkg.sv
hdl/ezrm_stream_if.sv
hdl/ezrm_cordic_cell.sv
hdl/ezrm_matrix.sv
hdl/euler_zyx_rotation_matrix_unit.sv
hdl/ezrm_checker.sv
tb/euler_zyx_rotation_matrix_unit_tb.sv
